// ----- design/plbq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbq_pkg: shared types and constants for the priority lane byte budget queue
// Field widths, status codes, register indexes and the per-request decision.
// ----------------------------------------------------------------------------
package plbq_pkg;

    // fixed field widths
    localparam int PRIO_W     = 2;
    localparam int LEN_W      = 16;
    localparam int TAG_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int OUT_LANE_W = 2;
    localparam int TOTAL_W    = 24;
    localparam int HDR_W      = 8;
    localparam int SIZE_W     = 17;
    localparam int CFG_IDX_W  = 2;

    // request kinds
    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_POP     = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUDGET    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LANE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUEUE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

    // configuration reset values
    localparam logic [TOTAL_W-1:0] RST_MAX_QUEUE   = 24'd1048576;
    localparam logic [HDR_W-1:0]   RST_HEADER      = 8'd8;
    localparam logic [LEN_W-1:0]   RST_MAX_PAYLOAD = 16'd65535;

    // outcome of one request, decided against the lane state
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                enq_ok;
        logic                pop_ok;
        logic [SIZE_W-1:0]   size;
    } t_decision;

endpackage

// ----- design/plbq_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbq_store: frame entry memory
// Tag and frame size per slot, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module plbq_store #(
    parameter int AW = 6,
    parameter int SW = 16
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_addr,
    input  logic [SW-1:0]             i_wr_tag,
    input  logic [plbq_pkg::SIZE_W-1:0] i_wr_size,
    output logic [SW-1:0]             o_rd_tag,
    output logic [plbq_pkg::SIZE_W-1:0] o_rd_size
);
    import plbq_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [SW-1:0]     r_tag_mem  [DEPTH];
    logic [SIZE_W-1:0] r_size_mem [DEPTH];
    logic [SW-1:0]     r_rd_tag;
    logic [SIZE_W-1:0] r_rd_size;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag_mem[i_addr]  <= i_wr_tag;
            r_size_mem[i_addr] <= i_wr_size;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_tag  <= r_tag_mem[i_addr];
            r_rd_size <= r_size_mem[i_addr];
        end
    end

    assign o_rd_tag  = r_rd_tag;
    assign o_rd_size = r_rd_size;

endmodule

// ----- design/plbq_lanes.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbq_lanes: lane state and request admission
// Head and count per lane, admission checks, pop lane selection, slot address.
// ----------------------------------------------------------------------------
module plbq_lanes #(
    parameter int LANE_COUNT = 4,
    parameter int LANE_DEPTH = 16,
    parameter int LW         = 2,
    parameter int HW         = 4,
    parameter int CW         = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_commit,
    input  logic                          i_req_type,
    input  logic [plbq_pkg::PRIO_W-1:0]   i_prio,
    input  logic [plbq_pkg::LEN_W-1:0]    i_payload_len,
    input  logic [plbq_pkg::TOTAL_W-1:0]  i_total,
    input  logic [plbq_pkg::TOTAL_W-1:0]  i_max_queue,
    input  logic [plbq_pkg::HDR_W-1:0]    i_header,
    input  logic [plbq_pkg::LEN_W-1:0]    i_max_payload,
    output plbq_pkg::t_decision           o_dec,
    output logic [LW-1:0]                 o_lane,
    output logic [LW+HW-1:0]              o_addr
);
    import plbq_pkg::*;

    logic [HW-1:0] r_head  [LANE_COUNT];
    logic [CW-1:0] r_count [LANE_COUNT];

    logic [SIZE_W-1:0]  size;
    logic [TOTAL_W-1:0] size_ext;
    logic               too_large;
    logic               over_budget;
    logic [LW-1:0]      enq_lane;
    logic               lane_full;
    logic [HW:0]        tail_sum;
    logic [HW-1:0]      tail_slot;
    logic               pop_any;
    logic [LW-1:0]      pop_lane;
    logic [HW-1:0]      head_inc;

    // admission checks for an enqueue
    always_comb begin
        size        = SIZE_W'(i_header) + SIZE_W'(i_payload_len);
        size_ext    = TOTAL_W'(size);
        too_large   = i_payload_len > i_max_payload;
        over_budget = (size_ext > i_max_queue) || (i_total > (i_max_queue - size_ext));
        if (32'(i_prio) >= LANE_COUNT) begin
            enq_lane = LW'(LANE_COUNT - 1);
        end else begin
            enq_lane = LW'(i_prio);
        end
        lane_full = r_count[enq_lane] == CW'(LANE_DEPTH);
        // tail slot, wrapped once past the lane depth
        tail_sum  = (HW+1)'(r_head[enq_lane]) + (HW+1)'(r_count[enq_lane]);
        if (tail_sum >= (HW+1)'(LANE_DEPTH)) begin
            tail_slot = HW'(tail_sum - (HW+1)'(LANE_DEPTH));
        end else begin
            tail_slot = HW'(tail_sum);
        end
    end

    // lowest-numbered non-empty lane wins a pop
    always_comb begin
        pop_any  = 1'b0;
        pop_lane = '0;
        for (int l = LANE_COUNT - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                pop_any  = 1'b1;
                pop_lane = LW'(l);
            end
        end
        if (r_head[pop_lane] == HW'(LANE_DEPTH - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = r_head[pop_lane] + HW'(1);
        end
    end

    // decision and memory address
    always_comb begin
        o_dec.status = ST_OK;
        o_dec.enq_ok = 1'b0;
        o_dec.pop_ok = 1'b0;
        o_dec.size   = size;
        o_lane       = '0;
        o_addr       = {enq_lane, tail_slot};
        if (i_req_type == REQ_POP) begin
            o_addr = {pop_lane, r_head[pop_lane]};
            if (pop_any) begin
                o_dec.pop_ok = 1'b1;
                o_lane       = pop_lane;
            end else begin
                o_dec.status = ST_EMPTY;
            end
        end else begin
            priority if (too_large) begin
                o_dec.status = ST_TOO_LARGE;
            end else if (over_budget) begin
                o_dec.status = ST_BUDGET;
            end else if (lane_full) begin
                o_dec.status = ST_LANE_FULL;
            end else begin
                o_dec.enq_ok = 1'b1;
            end
        end
    end

    // lane state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANE_COUNT; l++) begin
                r_head[l]  <= '0;
                r_count[l] <= '0;
            end
        end else if (i_commit) begin
            if (o_dec.enq_ok) begin
                r_count[enq_lane] <= r_count[enq_lane] + CW'(1);
            end
            if (o_dec.pop_ok) begin
                r_head[pop_lane]  <= head_inc;
                r_count[pop_lane] <= r_count[pop_lane] - CW'(1);
            end
        end
    end

    // lane occupancy never passes the depth
    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_chk
        a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_count[g] <= CW'(LANE_DEPTH))
            else $error("lane count above depth");
    end

    // a committed enqueue never lands in a full lane
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && o_dec.enq_ok |-> !lane_full)
        else $error("enqueue into full lane");

    // a pop is only granted when some lane holds a frame
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && o_dec.pop_ok |-> r_count[pop_lane] != '0)
        else $error("pop from empty lane");

endmodule

// ----- design/plbq_budget.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbq_budget: queued byte total
// Adds admitted frame sizes and subtracts popped ones, floored at zero.
// ----------------------------------------------------------------------------
module plbq_budget (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_commit,
    input  logic                          i_enq_ok,
    input  logic                          i_pop_ok,
    input  logic [plbq_pkg::SIZE_W-1:0]   i_enq_size,
    input  logic [plbq_pkg::SIZE_W-1:0]   i_pop_size,
    output logic [plbq_pkg::TOTAL_W-1:0]  o_total_next
);
    import plbq_pkg::*;

    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic [TOTAL_W-1:0] pop_ext;

    // next total for the request now in the data stage
    always_comb begin
        pop_ext = TOTAL_W'(i_pop_size);
        n_total = r_total;
        if (i_enq_ok) begin
            n_total = r_total + TOTAL_W'(i_enq_size);
        end else if (i_pop_ok) begin
            n_total = (pop_ext > r_total) ? '0 : (r_total - pop_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_commit) begin
            r_total <= n_total;
        end
    end

    assign o_total_next = n_total;

endmodule

// ----- design/priority_lane_byte_budget_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_lane_byte_budget_queue: strict priority frame queue with byte budget
// Enqueue and pop requests against LANE_COUNT lanes sharing one byte budget.
// ----------------------------------------------------------------------------
// One request is taken per clock while the output is not stalled, and every
// request gives exactly one result, through three registers: an input register
// where the lane state is checked and the entry memory is accessed, a data
// stage where the registered memory read returns the popped frame and the byte
// total is updated, and the output register. The data stage's new total is fed
// straight back to the admission check, so back-to-back requests see each
// other's effect. Lane 0 is served first on a pop; an enqueue is checked for
// payload size, then budget, then lane space, and a rejected enqueue changes
// nothing. A full output register that is stalled holds the whole pipeline.
module priority_lane_byte_budget_queue #(
    parameter int LANE_COUNT = 4,
    parameter int LANE_DEPTH = 16,
    parameter int TAG_BITS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_req_type,
    input  logic [plbq_pkg::PRIO_W-1:0]      i_priority_req,
    input  logic [plbq_pkg::LEN_W-1:0]       i_payload_len,
    input  logic [plbq_pkg::TAG_W-1:0]       i_message_tag,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [plbq_pkg::STATUS_W-1:0]    o_status,
    output logic [plbq_pkg::OUT_LANE_W-1:0]  o_out_lane,
    output logic [plbq_pkg::TAG_W-1:0]       o_out_tag,
    output logic [plbq_pkg::TOTAL_W-1:0]     o_total_bytes,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [plbq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [plbq_pkg::TOTAL_W-1:0]     i_cfg_data
);
    import plbq_pkg::*;

    localparam int LW = $clog2(LANE_COUNT);
    localparam int HW = $clog2(LANE_DEPTH);
    localparam int CW = $clog2(LANE_DEPTH + 1);
    localparam int AW = LW + HW;
    localparam int SW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    // configuration registers
    logic [TOTAL_W-1:0] r_max_queue;
    logic [HDR_W-1:0]   r_header;
    logic [LEN_W-1:0]   r_max_payload;

    // input stage
    logic               r_a_valid;
    logic               r_a_type;
    logic [PRIO_W-1:0]  r_a_prio;
    logic [LEN_W-1:0]   r_a_len;
    logic [TAG_W-1:0]   r_a_tag;

    // data stage
    logic               r_b_valid;
    t_decision          r_b_dec;
    logic [LW-1:0]      r_b_lane;

    // output stage
    logic                  r_c_valid;
    logic [STATUS_W-1:0]   r_c_status;
    logic [OUT_LANE_W-1:0] r_c_lane;
    logic [TAG_W-1:0]      r_c_tag;
    logic [TOTAL_W-1:0]    r_c_total;

    logic               adv;
    logic               commit_a;
    logic               commit_b;
    t_decision          a_dec;
    logic [LW-1:0]      a_lane;
    logic [AW-1:0]      a_addr;
    logic [SW-1:0]      rd_tag;
    logic [SIZE_W-1:0]  rd_size;
    logic [TOTAL_W-1:0] total_next;

    // pipeline moves whenever the output register can take a result
    assign adv      = !r_c_valid || !i_stall;
    assign o_stall  = !adv;
    assign commit_a = adv && r_a_valid;
    assign commit_b = adv && r_b_valid;

    // configuration writes, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_queue   <= RST_MAX_QUEUE;
            r_header      <= RST_HEADER;
            r_max_payload <= RST_MAX_PAYLOAD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAX_QUEUE:   r_max_queue   <= i_cfg_data;
                CFG_HEADER:      r_header      <= i_cfg_data[HDR_W-1:0];
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_a_type <= i_req_type;
            r_a_prio <= i_priority_req;
            r_a_len  <= i_payload_len;
            r_a_tag  <= i_message_tag;
        end
    end

    // lane state and admission
    plbq_lanes #(
        .LANE_COUNT (LANE_COUNT),
        .LANE_DEPTH (LANE_DEPTH),
        .LW         (LW),
        .HW         (HW),
        .CW         (CW)
    ) u_lanes (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_commit      (commit_a),
        .i_req_type    (r_a_type),
        .i_prio        (r_a_prio),
        .i_payload_len (r_a_len),
        .i_total       (total_next),
        .i_max_queue   (r_max_queue),
        .i_header      (r_header),
        .i_max_payload (r_max_payload),
        .o_dec         (a_dec),
        .o_lane        (a_lane),
        .o_addr        (a_addr)
    );

    // frame entry memory
    plbq_store #(
        .AW (AW),
        .SW (SW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (commit_a && a_dec.enq_ok),
        .i_rd_en   (commit_a && a_dec.pop_ok),
        .i_addr    (a_addr),
        .i_wr_tag  (SW'(r_a_tag)),
        .i_wr_size (a_dec.size),
        .o_rd_tag  (rd_tag),
        .o_rd_size (rd_size)
    );

    // data stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_a) begin
            r_b_dec  <= a_dec;
            r_b_lane <= a_lane;
        end
    end

    // byte total, forwarded to the admission check
    plbq_budget u_budget (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_commit     (commit_b),
        .i_enq_ok     (r_b_valid && r_b_dec.enq_ok),
        .i_pop_ok     (r_b_valid && r_b_dec.pop_ok),
        .i_enq_size   (r_b_dec.size),
        .i_pop_size   (rd_size),
        .o_total_next (total_next)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_b) begin
            r_c_status <= r_b_dec.status;
            r_c_lane   <= OUT_LANE_W'(r_b_lane);
            r_c_tag    <= r_b_dec.pop_ok ? TAG_W'(rd_tag) : '0;
            r_c_total  <= total_next;
        end
    end

    assign o_valid       = r_c_valid;
    assign o_status      = r_c_status;
    assign o_out_lane    = r_c_lane;
    assign o_out_tag     = r_c_tag;
    assign o_total_bytes = r_c_total;

    // a popped frame's size never exceeds the new total plus that size
    a_pop_within_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_dec.pop_ok |-> TOTAL_W'(rd_size) <= total_next + TOTAL_W'(rd_size))
        else $error("popped size exceeds total");

    // a request cannot both enqueue and pop
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> !(r_b_dec.enq_ok && r_b_dec.pop_ok))
        else $error("decision both enqueue and pop");

    // an empty pop reports lane zero and tag zero
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_out_lane == '0 && o_out_tag == '0)
        else $error("empty pop carries lane or tag");

    // an admitted enqueue reports OK with the total computed in its data stage
    a_enq_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit_b && r_b_dec.enq_ok |=>
            r_c_total == $past(total_next) && r_c_status == ST_OK)
        else $error("enqueue total mismatch");

endmodule
